// File: hdl/libr_pkg.sv
// ----------------------------------------------------------------------------
// libr_pkg
// Shared types and constants of the block resampler.
// ----------------------------------------------------------------------------
package libr_pkg;

    localparam int BLOCK_FRAMES = 16;
    localparam int MAX_OUT      = 64;
    localparam int FRAC_BITS    = 12;
    localparam int IDX_W        = $clog2(BLOCK_FRAMES);
    localparam int CNT_W        = $clog2(BLOCK_FRAMES + 1);
    localparam int OCNT_W       = $clog2(MAX_OUT + 1);
    localparam int RATE_W       = 18;
    localparam int PROD_W       = CNT_W + RATE_W;
    localparam int STEPN_W      = CNT_W + FRAC_BITS;
    localparam int PHASE_W      = STEPN_W + 1;

    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_FORMAT   = 3'd1;
    localparam logic [2:0] REG_SWAP     = 3'd2;
    localparam logic [2:0] REG_IN_RATE  = 3'd3;
    localparam logic [2:0] REG_OUT_RATE = 3'd4;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S8  = 2'd1;
    localparam logic [1:0] FMT_U16 = 2'd2;
    localparam logic [1:0] FMT_S16 = 2'd3;

    typedef struct packed {
        logic [15:0] left_sample;
        logic [15:0] right_sample;
        logic        block_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] left_out;
        logic [15:0] right_out;
        logic        run_end;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [1:0] fmt;
        logic       swap;
    } t_fmt_ctl;

    function automatic logic [15:0] decode_sample(input logic [15:0] raw,
                                                  input t_fmt_ctl c);
        logic [15:0] v;
        v = raw;
        if (c.fmt == FMT_U16 || c.fmt == FMT_S16) begin
            if (c.swap) v = {raw[7:0], raw[15:8]};
            if (c.fmt == FMT_S16) v[15] = ~v[15];
        end else begin
            v = {8'd0, raw[7:0]};
            if (c.fmt == FMT_S8) v[7] = ~v[7];
        end
        return v;
    endfunction

    function automatic logic [15:0] encode_sample(input logic [15:0] val,
                                                  input t_fmt_ctl c);
        logic [15:0] v;
        v = val;
        if (c.fmt == FMT_U16 || c.fmt == FMT_S16) begin
            if (c.fmt == FMT_S16) v[15] = ~v[15];
            if (c.swap) v = {v[7:0], v[15:8]};
        end else begin
            v = {8'd0, val[7:0]};
            if (c.fmt == FMT_S8) v[7] = ~v[7];
        end
        return v;
    endfunction

endpackage

// File: hdl/linear_interp_block_resampler_core.sv
// ----------------------------------------------------------------------------
// linear_interp_block_resampler_core
// Stores a block of PCM frames and emits a linearly interpolated run of
// output frames at the configured rate ratio.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  in        sink       i_valid/o_stall  t_in_item
//  out       source     o_valid/i_stall  t_out_item
//  cfg       sink       i_cfg_valid/o_cfg_ready  index, data
//
// A frame that does not end a block is accepted while the core is loading.
// A block end starts two serial divisions, one after the other (count,
// then step); then each output frame passes through the read, multiply and
// output states (store read, lane multipliers registered, item presented)
// plus any stall on the output. Input is stalled from the block end until
// the last output item has been taken. Reset is synchronous and clears
// control state; the frame store is not cleared.
module linear_interp_block_resampler_core
    import libr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_cfg_write  i_cfg
);

    typedef enum logic [5:0] {
        ST_LOAD  = 6'b000001,
        ST_DIV1  = 6'b000010,
        ST_DIV2  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [1:0]        r_chan;
    logic [1:0]        r_fmt;
    logic              r_swap;
    logic [RATE_W-1:0] r_in_rate;
    logic [RATE_W-1:0] r_out_rate;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan     <= 2'd2;
            r_fmt      <= FMT_S16;
            r_swap     <= 1'b0;
            r_in_rate  <= RATE_W'(44100);
            r_out_rate <= RATE_W'(48000);
        end else if (i_cfg_valid) begin
            unique case (i_cfg.index)
                REG_CHANNELS: r_chan     <= i_cfg.data[1:0];
                REG_FORMAT:   r_fmt      <= i_cfg.data[1:0];
                REG_SWAP:     r_swap     <= i_cfg.data[0];
                REG_IN_RATE:  r_in_rate  <= i_cfg.data[RATE_W-1:0];
                REG_OUT_RATE: r_out_rate <= i_cfg.data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame store, one frame per entry; right channel in the upper half.
    logic [31:0] r_store [BLOCK_FRAMES];
    logic [31:0] r_s0;
    logic [31:0] r_s1;

    logic [CNT_W-1:0]   r_n;
    logic [OCNT_W-1:0]  r_count;
    logic [OCNT_W-1:0]  r_k;
    logic [STEPN_W-1:0] r_step;
    logic [PHASE_W-1:0] r_x;
    logic [FRAC_BITS-1:0] r_frac;
    logic               r_last;

    logic in_acc;
    assign o_stall = (r_state != ST_LOAD);
    assign in_acc  = i_valid && !o_stall;

    // Shared divider: first n*out_rate/in_rate, then (n<<12)/count.
    logic              div_start;
    logic [PROD_W-1:0] div_num;
    logic [RATE_W-1:0] div_den;
    logic              div_done;
    logic [PROD_W-1:0] div_quot;

    libr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic [CNT_W-1:0] n_fill;
    logic             blk_done;
    assign n_fill   = r_n + 1'b1;
    assign blk_done = in_acc && (i_item.block_end || n_fill == CNT_W'(BLOCK_FRAMES));

    logic [OCNT_W-1:0] n_cnt_sat;
    assign n_cnt_sat = (div_quot > PROD_W'(MAX_OUT)) ? OCNT_W'(MAX_OUT)
                                                      : div_quot[OCNT_W-1:0];

    always_comb begin
        div_start = 1'b0;
        div_num   = PROD_W'(n_fill) * PROD_W'(r_out_rate);
        div_den   = r_in_rate;
        if (blk_done && r_in_rate != '0) begin
            div_start = 1'b1;
        end else if (r_state == ST_DIV1 && div_done && n_cnt_sat != '0) begin
            div_start = 1'b1;
            div_num   = PROD_W'({r_n, {FRAC_BITS{1'b0}}});
            div_den   = RATE_W'(n_cnt_sat);
        end
    end

    // Clamped neighbor indices.
    logic [PHASE_W-1:0] i0_w;
    logic [IDX_W-1:0]   i0;
    logic [IDX_W-1:0]   i1;
    logic [CNT_W-1:0]   n_last;
    assign n_last = r_n - 1'b1;
    assign i0_w   = r_x >> FRAC_BITS;
    assign i0 = (i0_w > PHASE_W'(n_last)) ? n_last[IDX_W-1:0] : i0_w[IDX_W-1:0];
    assign i1 = ({1'b0, i0} + 1'b1 > (IDX_W+1)'(n_last)) ? n_last[IDX_W-1:0]
                                                           : IDX_W'(i0 + 1'b1);

    always_ff @(posedge i_clk) begin
        if (in_acc) r_store[r_n[IDX_W-1:0]] <= {i_item.right_sample, i_item.left_sample};
        if (r_state == ST_READ) begin
            r_s0   <= r_store[i0];
            r_s1   <= r_store[i1];
            r_frac <= r_x[FRAC_BITS-1:0];
            r_last <= (r_k + 1'b1 == r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_n     <= '0;
            r_k     <= '0;
            r_x     <= '0;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_n <= n_fill;
                        if (blk_done) begin
                            if (r_in_rate != '0) r_state <= ST_DIV1;
                            else r_n <= '0;
                        end
                    end
                end
                ST_DIV1: begin
                    if (div_done) begin
                        r_count <= n_cnt_sat;
                        if (n_cnt_sat == '0) begin
                            r_n     <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_DIV2;
                        end
                    end
                end
                ST_DIV2: begin
                    if (div_done) begin
                        r_step  <= div_quot[STEPN_W-1:0];
                        r_x     <= '0;
                        r_k     <= '0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_MUL;
                ST_MUL:  r_state <= ST_OUT;
                ST_OUT: begin
                    if (!i_stall) begin
                        r_x <= r_x + PHASE_W'(r_step);
                        r_k <= r_k + 1'b1;
                        if (r_last) begin
                            r_n     <= '0;
                            r_state <= ST_LOAD;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    // Two lanes, one per channel; the merge packs them into one item.
    t_fmt_ctl    ctl;
    logic [15:0] lane_l;
    logic [15:0] lane_r;
    assign ctl.fmt  = r_fmt;
    assign ctl.swap = r_swap;

    libr_lane u_lane_l (
        .i_clk (i_clk), .i_raw0 (r_s0[15:0]), .i_raw1 (r_s1[15:0]),
        .i_frac (r_frac), .i_ctl (ctl), .o_sample (lane_l)
    );

    libr_lane u_lane_r (
        .i_clk (i_clk), .i_raw0 (r_s0[31:16]), .i_raw1 (r_s1[31:16]),
        .i_frac (r_frac), .i_ctl (ctl), .o_sample (lane_r)
    );

    assign o_valid          = (r_state == ST_OUT);
    assign o_item.left_out  = lane_l;
    assign o_item.right_out = (r_chan != 2'd1) ? lane_r : 16'd0;
    assign o_item.run_end   = r_last;

endmodule

// File: hdl/libr_divider.sv
// ----------------------------------------------------------------------------
// libr_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module libr_divider
    import libr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PROD_W-1:0]   i_num,
    input  logic [RATE_W-1:0]   i_den,
    output logic                o_done,
    output logic [PROD_W-1:0]   o_quot
);

    localparam int BIT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] r_quot;
    logic [RATE_W-1:0] r_rem;
    logic [BIT_W-1:0]  r_bits;
    logic              r_busy;
    logic              r_done;
    logic [RATE_W-1:0] r_den;
    logic [RATE_W:0]   n_trial;

    assign n_trial = {r_rem, r_quot[PROD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bits <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_bits <= BIT_W'(PROD_W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_den}) begin
                    r_rem  <= RATE_W'(n_trial - {1'b0, r_den});
                    r_quot <= {r_quot[PROD_W-2:0], 1'b1};
                end else begin
                    r_rem  <= n_trial[RATE_W-1:0];
                    r_quot <= {r_quot[PROD_W-2:0], 1'b0};
                end
                r_bits <= r_bits - 1'b1;
                if (r_bits == BIT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: hdl/libr_lane.sv
// ----------------------------------------------------------------------------
// libr_lane
// One channel lane: decode both neighbors, weight, shift and encode.
// ----------------------------------------------------------------------------
module libr_lane
    import libr_pkg::*;
(
    input  logic                 i_clk,
    input  logic [15:0]          i_raw0,
    input  logic [15:0]          i_raw1,
    input  logic [FRAC_BITS-1:0] i_frac,
    input  t_fmt_ctl             i_ctl,
    output logic [15:0]          o_sample
);

    logic [15:0]          n_a;
    logic [15:0]          n_b;
    logic [FRAC_BITS:0]   n_wa;
    logic [16+FRAC_BITS:0] r_pa;
    logic [16+FRAC_BITS:0] r_pb;
    logic [16+FRAC_BITS:0] n_sum;

    assign n_a  = decode_sample(i_raw0, i_ctl);
    assign n_b  = decode_sample(i_raw1, i_ctl);
    assign n_wa = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        r_pa <= (17+FRAC_BITS)'(n_a * n_wa);
        r_pb <= (17+FRAC_BITS)'(n_b * {1'b0, i_frac});
    end

    assign n_sum    = r_pa + r_pb;
    assign o_sample = encode_sample(n_sum[FRAC_BITS+15:FRAC_BITS], i_ctl);

endmodule
